/* src/psh_pkg.sv */
// Shared types, codes and constants for the pair-state histogram.
`default_nettype none
package psh_pkg;

  // Default sizing handed to the top-level parameters
  localparam int DEF_NUM_POSITIONS = 65536;
  localparam int DEF_COUNT_WIDTH   = 16;

  // Field widths of the channels
  localparam int POS_W   = 16;
  localparam int BASE_W  = 8;
  localparam int OUT_W   = 16;
  localparam int TOTAL_W = 18;

  // Op queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Request types
  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Base characters
  localparam logic [BASE_W-1:0] BASE_C = 8'h43;
  localparam logic [BASE_W-1:0] BASE_T = 8'h54;

  // Pair codes, also the lane index of the counter in a store entry
  localparam logic [1:0] PAIR_CC = 2'd0;
  localparam logic [1:0] PAIR_CT = 2'd1;
  localparam logic [1:0] PAIR_TC = 2'd2;
  localparam logic [1:0] PAIR_TT = 2'd3;
  localparam int         NUM_LANES = 4;

  // One classified operation for the back end
  typedef struct packed {
    logic             is_read;
    logic             in_range;
    logic [1:0]       pair;
    logic [POS_W-1:0] pos;
  } op_t;

  // Pair classification: bit 2 set when the pair is countable
  function automatic logic [2:0] classify_pair(input logic [BASE_W-1:0] a,
                                               input logic [BASE_W-1:0] b);
    logic       ok;
    logic [1:0] code;
    ok   = 1'b1;
    code = PAIR_CC;
    if (a == BASE_C) begin
      code = PAIR_CC;
    end else if (a == BASE_T) begin
      code = PAIR_TC;
    end else begin
      ok = 1'b0;
    end
    if (b == BASE_T) begin
      code = code | PAIR_CT;
    end else if (b != BASE_C) begin
      ok = 1'b0;
    end
    return {ok, code};
  endfunction

endpackage
`default_nettype wire

/* src/pair_state_histogram_top.sv */
// Top level of the pair-state histogram: front end, op queue, back end.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | req_type, position, first_base, second_base
//  out_    | output    | out_valid / out_ready | count_cc, count_ct, count_tc, count_tt,
//          |           |                       | count_total
//
// The front end takes one request per cycle while the four-entry op queue has room.
// For each queued op the back end first reads the counter entry from the
// single-port-read store, then writes it back or loads the result register.
// Counts of unknown pairs or out-of-range positions are dropped in the front end.
// After reset a clearing pass writes zero to all NUM_POSITIONS entries, one per
// cycle; in_ready stays low during the pass.
// A stalled result register holds the back end only while it executes a read.
`default_nettype none
module pair_state_histogram_top #(
  parameter int NUM_POSITIONS = psh_pkg::DEF_NUM_POSITIONS,
  parameter int COUNT_WIDTH   = psh_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_req_type,
  input  wire logic [psh_pkg::POS_W-1:0]    in_position,
  input  wire logic [psh_pkg::BASE_W-1:0]   in_first_base,
  input  wire logic [psh_pkg::BASE_W-1:0]   in_second_base,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [psh_pkg::OUT_W-1:0]         out_count_cc,
  output logic [psh_pkg::OUT_W-1:0]         out_count_ct,
  output logic [psh_pkg::OUT_W-1:0]         out_count_tc,
  output logic [psh_pkg::OUT_W-1:0]         out_count_tt,
  output logic [psh_pkg::TOTAL_W-1:0]       out_count_total
);
  import psh_pkg::*;

  logic clear_busy;
  logic q_ready;
  logic q_push;
  op_t  q_push_op;
  logic q_pop;
  logic q_valid;
  op_t  q_head_op;

  psh_front #(
    .NUM_POSITIONS (NUM_POSITIONS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_first_base  (in_first_base),
    .in_second_base (in_second_base),
    .clear_busy     (clear_busy),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_op           (q_push_op)
  );

  psh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_op     (q_head_op)
  );

  psh_back #(
    .NUM_POSITIONS (NUM_POSITIONS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_op            (q_head_op),
    .q_pop           (q_pop),
    .clear_busy      (clear_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_count_cc    (out_count_cc),
    .out_count_ct    (out_count_ct),
    .out_count_tc    (out_count_tc),
    .out_count_tt    (out_count_tt),
    .out_count_total (out_count_total)
  );

endmodule
`default_nettype wire

/* src/psh_queue.sv */
// Short FIFO of classified operations between the front and the back end.
`default_nettype none
module psh_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire psh_pkg::op_t push_op,
  output logic            push_ready,
  input  wire logic       pop,
  output logic            pop_valid,
  output psh_pkg::op_t    pop_op
);
  import psh_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);

  op_t            slot_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != (QAW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_op     = slot_r[rd_ptr_r];

  assign do_push = push && push_ready;
  assign do_pop  = pop && pop_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule
`default_nettype wire

/* src/psh_front.sv */
// Front end: accepts requests, classifies base pairs, drops no-op counts.
`default_nettype none
module psh_front #(
  parameter int NUM_POSITIONS = psh_pkg::DEF_NUM_POSITIONS
) (
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_req_type,
  input  wire logic [psh_pkg::POS_W-1:0]  in_position,
  input  wire logic [psh_pkg::BASE_W-1:0] in_first_base,
  input  wire logic [psh_pkg::BASE_W-1:0] in_second_base,
  input  wire logic                       clear_busy,
  input  wire logic                       q_ready,
  output logic                            q_push,
  output psh_pkg::op_t                    q_op
);
  import psh_pkg::*;

  logic [2:0] cls;
  logic       in_range;
  logic       xfer;
  logic       keep;

  // No transfer while the store is being cleared or the queue is full
  assign in_ready = q_ready && !clear_busy;
  assign xfer     = in_valid && in_ready;

  assign cls      = classify_pair(in_first_base, in_second_base);
  assign in_range = (32'(in_position) < 32'(NUM_POSITIONS));

  // Reads always go on; counts only when they change the store
  assign keep   = (in_req_type == REQ_READ) || (in_range && cls[2]);
  assign q_push = xfer && keep;

  always_comb begin
    q_op.is_read  = (in_req_type == REQ_READ);
    q_op.in_range = in_range;
    q_op.pair     = cls[1:0];
    q_op.pos      = in_position;
  end

endmodule
`default_nettype wire

/* src/psh_back.sv */
// Back end: counter store with clearing pass, read-modify-write, result register.
`default_nettype none
module psh_back #(
  parameter int NUM_POSITIONS = psh_pkg::DEF_NUM_POSITIONS,
  parameter int COUNT_WIDTH   = psh_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire psh_pkg::op_t                 q_op,
  output logic                              q_pop,
  output logic                              clear_busy,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [psh_pkg::OUT_W-1:0]         out_count_cc,
  output logic [psh_pkg::OUT_W-1:0]         out_count_ct,
  output logic [psh_pkg::OUT_W-1:0]         out_count_tc,
  output logic [psh_pkg::OUT_W-1:0]         out_count_tt,
  output logic [psh_pkg::TOTAL_W-1:0]       out_count_total
);
  import psh_pkg::*;

  localparam int AW  = $clog2(NUM_POSITIONS);
  localparam int CW  = COUNT_WIDTH;
  localparam int EW  = NUM_LANES * CW;
  localparam int SW  = CW + 2;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [EW-1:0]  mem [NUM_POSITIONS];
  logic [EW-1:0]  rd_data_r;

  logic [1:0]     state_r, state_nxt;
  logic [AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  op_t            op_r;

  logic           we;
  logic [AW-1:0]  wr_addr;
  logic [EW-1:0]  wr_data;
  logic [AW-1:0]  rd_addr;
  logic [EW-1:0]  inc_data;
  logic           load_out;

  logic [CW-1:0]  lane [NUM_LANES];
  logic [SW-1:0]  sum;
  logic [31:0]    lane_ext [NUM_LANES];
  logic [33:0]    sum_ext;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    cc_r, ct_r, tc_r, tt_r;
  logic [TOTAL_W-1:0]  total_r;

  assign clear_busy = (state_r == ST_CLEAR);
  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign rd_addr    = AW'(q_op.pos);

  // Split the entry that was read into its counters
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      lane[k]     = rd_data_r[k*CW +: CW];
      lane_ext[k] = 32'(lane[k]);
    end
  end

  // Bump the selected counter, wrapping at CW bits
  always_comb begin
    inc_data = rd_data_r;
    for (int k = 0; k < NUM_LANES; k++) begin
      if (op_r.pair == 2'(k)) begin
        inc_data[k*CW +: CW] = lane[k] + 1'b1;
      end
    end
  end

  // Total of the four full counters
  assign sum     = SW'(lane[0]) + SW'(lane[1]) + SW'(lane[2]) + SW'(lane[3]);
  assign sum_ext = 34'(sum);

  // Read result goes out when the result register is free or being drained
  assign load_out = (state_r == ST_EXEC) && op_r.is_read && (!out_valid_r || out_ready);

  // Store write port: clearing pass or counter update
  always_comb begin
    we      = 1'b0;
    wr_addr = AW'(op_r.pos);
    wr_data = inc_data;
    if (state_r == ST_CLEAR) begin
      we      = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (state_r == ST_EXEC && !op_r.is_read) begin
      we = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(NUM_POSITIONS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!op_r.is_read || load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Counter store with registered read; read data held while the op executes
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Operation being executed
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_op;
    end
  end

  // Result register; out-of-range reads return zeros
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (op_r.in_range) begin
        cc_r    <= lane_ext[PAIR_CC][OUT_W-1:0];
        ct_r    <= lane_ext[PAIR_CT][OUT_W-1:0];
        tc_r    <= lane_ext[PAIR_TC][OUT_W-1:0];
        tt_r    <= lane_ext[PAIR_TT][OUT_W-1:0];
        total_r <= sum_ext[TOTAL_W-1:0];
      end else begin
        cc_r    <= '0;
        ct_r    <= '0;
        tc_r    <= '0;
        tt_r    <= '0;
        total_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_count_cc    = cc_r;
  assign out_count_ct    = ct_r;
  assign out_count_tc    = tc_r;
  assign out_count_tt    = tt_r;
  assign out_count_total = total_r;

endmodule
`default_nettype wire

/* verif/pair_state_histogram_top_test.sv */
// Self-checking testbench for the pair-state histogram: directed, burst and random traffic.
`timescale 1ns / 1ps
module pair_state_histogram_top_test;
  import psh_pkg::*;

  // Expected contents of one read result
  typedef struct packed {
    logic [OUT_W-1:0]   cc;
    logic [OUT_W-1:0]   ct;
    logic [OUT_W-1:0]   tc;
    logic [OUT_W-1:0]   tt;
    logic [TOTAL_W-1:0] total;
  } tally_t;

  // Tracks the counter store and the queue of pending read results
  class pair_count_board;
    logic [4*OUT_W-1:0] store_q [logic [POS_W-1:0]];
    tally_t             tally_q [$];
    int                 mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Lane of a countable pair, -1 when the pair is ignored
    function int pair_lane(logic [BASE_W-1:0] a, logic [BASE_W-1:0] b);
      int hi;
      int lo;
      case (a)
        BASE_C:  hi = PAIR_CC;
        BASE_T:  hi = PAIR_TC;
        default: return -1;
      endcase
      case (b)
        BASE_C:  lo = 0;
        BASE_T:  lo = PAIR_CT;
        default: return -1;
      endcase
      return hi + lo;
    endfunction

    // Apply one accepted input transfer to the store
    function void note_request(logic req, logic [POS_W-1:0] pos,
                               logic [BASE_W-1:0] a, logic [BASE_W-1:0] b);
      logic [4*OUT_W-1:0] word;
      int                 lane;
      tally_t             t;
      word = store_q.exists(pos) ? store_q[pos] : '0;
      if (req == REQ_COUNT) begin
        lane = pair_lane(a, b);
        if (lane >= 0) begin
          word[OUT_W*lane +: OUT_W] = word[OUT_W*lane +: OUT_W] + 1'b1;
          store_q[pos] = word;
        end
      end else begin
        t.cc    = word[OUT_W*PAIR_CC +: OUT_W];
        t.ct    = word[OUT_W*PAIR_CT +: OUT_W];
        t.tc    = word[OUT_W*PAIR_TC +: OUT_W];
        t.tt    = word[OUT_W*PAIR_TT +: OUT_W];
        t.total = TOTAL_W'(t.cc) + TOTAL_W'(t.ct) + TOTAL_W'(t.tc) + TOTAL_W'(t.tt);
        tally_q.insert(tally_q.size(), t);
      end
    endfunction

    // Compare one accepted result transfer with the oldest expectation
    task check_result(tally_t got);
      tally_t want;
      if (tally_q.size() == 0) begin
        report("result transfer with nothing pending");
        return;
      end
      want = tally_q.pop_front();
      if (got.cc !== want.cc)
        report($sformatf("count_cc got %0d want %0d", got.cc, want.cc));
      if (got.ct !== want.ct)
        report($sformatf("count_ct got %0d want %0d", got.ct, want.ct));
      if (got.tc !== want.tc)
        report($sformatf("count_tc got %0d want %0d", got.tc, want.tc));
      if (got.tt !== want.tt)
        report($sformatf("count_tt got %0d want %0d", got.tt, want.tt));
      if (got.total !== want.total)
        report($sformatf("count_total got %0d want %0d", got.total, want.total));
    endtask
  endclass

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic                 in_req_type     = REQ_COUNT;
  logic [POS_W-1:0]     in_position     = '0;
  logic [BASE_W-1:0]    in_first_base   = '0;
  logic [BASE_W-1:0]    in_second_base  = '0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [OUT_W-1:0]     out_count_cc;
  logic [OUT_W-1:0]     out_count_ct;
  logic [OUT_W-1:0]     out_count_tc;
  logic [OUT_W-1:0]     out_count_tt;
  logic [TOTAL_W-1:0]   out_count_total;

  pair_count_board board = new();
  bit              tx_steady = 1'b0;
  bit              rx_steady = 1'b0;
  int              rx_hold   = 0;
  logic [POS_W-1:0] hot_pos [8];

  pair_state_histogram_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_position     (in_position),
    .in_first_base   (in_first_base),
    .in_second_base  (in_second_base),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_count_cc    (out_count_cc),
    .out_count_ct    (out_count_ct),
    .out_count_tc    (out_count_tc),
    .out_count_tt    (out_count_tt),
    .out_count_total (out_count_total)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  // Base byte: mostly C/T, some near misses, some arbitrary bytes
  function automatic logic [BASE_W-1:0] pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return r[0] ? BASE_T : BASE_C;
    if (r == 8) begin
      case ($urandom_range(0, 4))
        0:       return "c";
        1:       return "t";
        2:       return "N";
        3:       return "A";
        default: return "G";
      endcase
    end
    return BASE_W'($urandom);
  endfunction

  // Drive one input transfer and wait for it to be taken
  task send_item(logic req, logic [POS_W-1:0] pos, logic [BASE_W-1:0] a,
                 logic [BASE_W-1:0] b, bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && !tx_steady && $urandom_range(0, 2) == 0) gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_position    <= pos;
    in_first_base  <= a;
    in_second_base <= b;
    do @(posedge clk); while (!in_ready);
    board.note_request(req, pos, a, b);
  endtask

  task wait_drained();
    while (board.tally_q.size() != 0) @(posedge clk);
  endtask

  // Result side: check transfers, stall at random
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      board.check_result({out_count_cc, out_count_ct, out_count_tc, out_count_tt,
                          out_count_total});
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_hold = gap_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stimulus
  initial begin
    logic req;
    logic [POS_W-1:0] pos;

    hot_pos[0] = '0;
    hot_pos[1] = '1;
    for (int i = 2; i < 8; i++) hot_pos[i] = POS_W'($urandom);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: store cleared, each pair, ignored bytes, bases on reads
    send_item(REQ_READ,  16'h0000, 8'h00,  8'h00,  1);
    send_item(REQ_READ,  16'hFFFF, 8'h00,  8'h00,  1);
    send_item(REQ_COUNT, 16'h0000, BASE_C, BASE_C, 1);
    send_item(REQ_COUNT, 16'h0000, BASE_C, BASE_T, 1);
    send_item(REQ_COUNT, 16'h0000, BASE_T, BASE_C, 1);
    send_item(REQ_COUNT, 16'h0000, BASE_T, BASE_T, 1);
    send_item(REQ_COUNT, 16'h0000, BASE_C, BASE_C, 1);
    send_item(REQ_COUNT, 16'hFFFF, BASE_T, BASE_T, 1);
    send_item(REQ_COUNT, 16'h0000, "c",    "c",    1);
    send_item(REQ_COUNT, 16'h0000, "t",    BASE_T, 1);
    send_item(REQ_COUNT, 16'h0000, "N",    BASE_C, 1);
    send_item(REQ_COUNT, 16'h0000, BASE_C, 8'h00,  1);
    send_item(REQ_COUNT, 16'h0000, 8'hFF,  BASE_T, 1);
    send_item(REQ_COUNT, 16'h0000, 8'h00,  8'hFF,  1);
    send_item(REQ_COUNT, 16'h0000, BASE_T, "G",    1);
    send_item(REQ_READ,  16'h0000, BASE_C, BASE_C, 1);
    send_item(REQ_READ,  16'hFFFF, 8'hFF,  8'hFF,  1);
    send_item(REQ_COUNT, 16'hAAAA, BASE_C, BASE_T, 1);
    send_item(REQ_COUNT, 16'h5555, BASE_T, BASE_C, 1);
    send_item(REQ_COUNT, 16'h5555, BASE_T, BASE_C, 1);
    send_item(REQ_READ,  16'hAAAA, BASE_T, BASE_T, 1);
    send_item(REQ_READ,  16'h5555, 8'h00,  8'h00,  1);

    // Back-to-back counts on one position fill the op queue
    for (int i = 0; i < 3; i++) send_item(REQ_COUNT, 16'h1234, BASE_C, BASE_T, 0);
    for (int i = 0; i < 20; i++) send_item(REQ_COUNT, 16'h1234, BASE_C, BASE_C, 0);
    send_item(REQ_READ,  16'h1234, 8'h00,  8'h00,  0);
    send_item(REQ_COUNT, 16'h1234, BASE_C, BASE_C, 0);
    send_item(REQ_READ,  16'h1234, 8'h00,  8'h00,  0);

    // Random traffic in phases with different idling on each side
    for (int phase = 0; phase < 4; phase++) begin
      tx_steady = (phase == 1);
      rx_steady = (phase == 2);
      for (int i = 0; i < 100; i++) begin
        req = ($urandom_range(0, 99) < 35) ? REQ_READ : REQ_COUNT;
        pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom) : hot_pos[$urandom_range(0, 7)];
        send_item(req, pos, pick_base(), pick_base(), 1);
      end
      // Sender holds off until every pending read has returned
      if (phase == 1) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: clearing pass, count burst and random traffic fit well inside this
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
